// ===== sv/rhv_pkg.sv =====
// rhv_pkg: types, codes and reset values for the readout header validator
// no dependencies; imported by the top level, rhv_check and rhv_seq
package rhv_pkg;

    localparam int QUEUE_COUNT_DEF = 32;

    localparam logic [23:0] COOKIE_VALUE = 24'h535345;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_BYTES = 3'd0;
    localparam logic [2:0] CFG_MAX_BYTES = 3'd1;
    localparam logic [2:0] CFG_HDR_V0    = 3'd2;
    localparam logic [2:0] CFG_HDR_V1    = 3'd3;
    localparam logic [2:0] CFG_MAX_FRAC  = 3'd4;
    localparam logic [2:0] CFG_LEN_CHECK = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_MIN_BYTES = 16'd30;
    localparam logic [15:0] RST_MAX_BYTES = 16'd8972;
    localparam logic [7:0]  RST_HDR_V0    = 8'd30;
    localparam logic [7:0]  RST_HDR_V1    = 8'd32;
    localparam logic [31:0] RST_MAX_FRAC  = 32'd88052499;
    localparam logic        RST_LEN_CHECK = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_BUF = 2'd1;
    localparam logic [1:0] ST_SIZE   = 2'd2;
    localparam logic [1:0] ST_HEADER = 2'd3;

    // error cause codes
    localparam logic [2:0] CS_NONE    = 3'd0;
    localparam logic [2:0] CS_BUFFER  = 3'd1;
    localparam logic [2:0] CS_SIZE    = 3'd2;
    localparam logic [2:0] CS_PAD     = 3'd3;
    localparam logic [2:0] CS_VERSION = 3'd4;
    localparam logic [2:0] CS_COOKIE  = 3'd5;
    localparam logic [2:0] CS_QUEUE   = 3'd6;
    localparam logic [2:0] CS_TIME    = 3'd7;

    typedef struct packed {
        logic [15:0] min_bytes;
        logic [15:0] max_bytes;
        logic [7:0]  hdr_v0;
        logic [7:0]  hdr_v1;
        logic [31:0] max_frac;
        logic        len_check;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  cause;
        logic        ver;
        logic        seq_chk;
        logic        hb;
        logic [15:0] plen;
    } t_check;

endpackage

// ===== sv/readout_header_validator.sv =====
// readout_header_validator: top level, config registers, two-stage pipeline
// depends on rhv_pkg, rhv_check, rhv_seq
// throughput: one word per cycle while not back-pressured, set by one sequence
// table read-modify-write per word, read in the accept cycle and written back
// as the word leaves stage one, with bypass
// reset: config takes its default values, every queue reads as expected zero
// at once through per-entry valid bits, no clearing pass
module readout_header_validator import rhv_pkg::*; #(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // buffer_present, received_size, pad_byte, format_version, cookie_word,
    // total_length, queue_number, sequence_number, pulse_fraction,
    // prev_pulse_fraction, zero fill
    input  logic [183:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, error_cause, sequence_error, heartbeat, version_out, payload_length
    output logic [23:0]  m_axis_tdata
);

    t_cfg        r_cfg;
    t_check      chk;
    t_check      r_s1_chk;
    logic        r_s1_vld;
    logic [QW-1:0] r_s1_addr;
    logic [31:0] r_s1_seq;
    logic        r_out_vld;
    logic [23:0] r_out_data;
    logic        seq_err;
    logic        in_fire;
    logic        s1_move;
    logic        commit;
    logic [7:0]  queue_number;

    assign queue_number = s_axis_tdata[80:73];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_bytes <= RST_MIN_BYTES;
            r_cfg.max_bytes <= RST_MAX_BYTES;
            r_cfg.hdr_v0    <= RST_HDR_V0;
            r_cfg.hdr_v1    <= RST_HDR_V1;
            r_cfg.max_frac  <= RST_MAX_FRAC;
            r_cfg.len_check <= RST_LEN_CHECK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_BYTES: r_cfg.min_bytes <= i_cfg_wdata[15:0];
                CFG_MAX_BYTES: r_cfg.max_bytes <= i_cfg_wdata[15:0];
                CFG_HDR_V0:    r_cfg.hdr_v0    <= i_cfg_wdata[7:0];
                CFG_HDR_V1:    r_cfg.hdr_v1    <= i_cfg_wdata[7:0];
                CFG_MAX_FRAC:  r_cfg.max_frac  <= i_cfg_wdata;
                CFG_LEN_CHECK: r_cfg.len_check <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rhv_check #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_check (
        .i_cfg                 (r_cfg),
        .i_buffer_present      (s_axis_tdata[0]),
        .i_received_size       (s_axis_tdata[16:1]),
        .i_pad_byte            (s_axis_tdata[24:17]),
        .i_format_version      (s_axis_tdata[32:25]),
        .i_cookie_word         (s_axis_tdata[56:33]),
        .i_total_length        (s_axis_tdata[72:57]),
        .i_queue_number        (queue_number),
        .i_pulse_fraction      (s_axis_tdata[144:113]),
        .i_prev_pulse_fraction (s_axis_tdata[176:145]),
        .o_check               (chk)
    );

    assign s1_move       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_s1_vld || s1_move;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign commit        = r_s1_vld && s1_move && r_s1_chk.seq_chk;

    rhv_seq #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_fire),
        .i_rd_addr  (queue_number[QW-1:0]),
        .i_upd_en   (commit),
        .i_upd_addr (r_s1_addr),
        .i_seq      (r_s1_seq),
        .o_seq_err  (seq_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_vld <= in_fire;
            end
            if (s1_move) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_chk  <= chk;
            r_s1_addr <= queue_number[QW-1:0];
            r_s1_seq  <= s_axis_tdata[112:81];
        end
        if (s1_move && r_s1_vld) begin
            r_out_data <= {r_s1_chk.plen, r_s1_chk.ver, r_s1_chk.hb,
                           (r_s1_chk.seq_chk && seq_err),
                           r_s1_chk.cause, r_s1_chk.status};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== sv/rhv_ram.sv =====
// rhv_ram: generic single write port, single read port ram with registered read
// no dependencies
module rhv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rhv_check.sv =====
// rhv_check: header checks in priority order, verdict ahead of the sequence check
// depends on rhv_pkg
module rhv_check import rhv_pkg::*; #(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  t_cfg        i_cfg,
    input  logic        i_buffer_present,
    input  logic [15:0] i_received_size,
    input  logic [7:0]  i_pad_byte,
    input  logic [7:0]  i_format_version,
    input  logic [23:0] i_cookie_word,
    input  logic [15:0] i_total_length,
    input  logic [7:0]  i_queue_number,
    input  logic [31:0] i_pulse_fraction,
    input  logic [31:0] i_prev_pulse_fraction,
    output t_check      o_check
);

    logic [15:0] hdr;
    logic        len_bad;
    logic        queue_bad;
    logic        time_bad;

    always_comb begin
        hdr       = {8'd0, (i_format_version[0] ? i_cfg.hdr_v1 : i_cfg.hdr_v0)};
        len_bad   = i_cfg.len_check &&
                    ((i_received_size != i_total_length) || (i_total_length < hdr));
        queue_bad = {1'b0, i_queue_number} >= 9'(QUEUE_COUNT);
        time_bad  = (i_pulse_fraction > i_cfg.max_frac) ||
                    (i_prev_pulse_fraction > i_cfg.max_frac);

        o_check = '0;
        if (!i_buffer_present || (i_received_size == 16'd0)) begin
            o_check.status = ST_NO_BUF;
            o_check.cause  = CS_BUFFER;
        end else if ((i_received_size < i_cfg.min_bytes) ||
                     (i_received_size > i_cfg.max_bytes)) begin
            o_check.status = ST_SIZE;
            o_check.cause  = CS_SIZE;
        end else if (i_pad_byte != 8'd0) begin
            o_check.status = ST_HEADER;
            o_check.cause  = CS_PAD;
        end else if (i_format_version > 8'd1) begin
            o_check.status = ST_HEADER;
            o_check.cause  = CS_VERSION;
        end else if (i_cookie_word != COOKIE_VALUE) begin
            o_check.status = ST_HEADER;
            o_check.cause  = CS_COOKIE;
        end else if ((i_received_size < hdr) || len_bad) begin
            o_check.status = ST_SIZE;
            o_check.cause  = CS_SIZE;
            o_check.ver    = i_format_version[0];
        end else if (queue_bad) begin
            o_check.status = ST_HEADER;
            o_check.cause  = CS_QUEUE;
            o_check.ver    = i_format_version[0];
        end else begin
            o_check.ver     = i_format_version[0];
            o_check.seq_chk = 1'b1;
            o_check.plen    = (i_total_length >= hdr) ? (i_total_length - hdr) : 16'd0;
            if (time_bad) begin
                o_check.status = ST_HEADER;
                o_check.cause  = CS_TIME;
            end else begin
                o_check.status = ST_OK;
                o_check.cause  = CS_NONE;
                o_check.hb     = (i_total_length == hdr);
            end
        end
    end

endmodule

// ===== sv/rhv_seq.sv =====
// rhv_seq: per-queue expected sequence table, read in the accept cycle,
// compared while the word sits in stage one and written back as it leaves; depends on rhv_pkg and rhv_ram
module rhv_seq import rhv_pkg::*; #(
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [QW-1:0] i_rd_addr,
    input  logic          i_upd_en,
    input  logic [QW-1:0] i_upd_addr,
    input  logic [31:0]   i_seq,
    output logic          o_seq_err
);

    logic [QUEUE_COUNT-1:0] r_valid;
    logic                   r_byp;
    logic [31:0]            r_byp_data;
    logic                   r_ent_vld;
    logic [31:0]            ram_q;
    logic [31:0]            seq_next;
    logic [31:0]            cur;

    // expected value after this word is always the received number plus one
    assign seq_next = i_seq + 32'd1;

    rhv_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_upd_en),
        .i_waddr (i_upd_addr),
        .i_wdata (seq_next),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_byp     <= 1'b0;
            r_ent_vld <= 1'b0;
        end else begin
            if (i_upd_en) begin
                r_valid[i_upd_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_byp     <= i_upd_en && (i_upd_addr == i_rd_addr);
                r_ent_vld <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= seq_next;
        end
    end

    // forward a write that lands on the same edge as the read
    assign cur       = r_byp ? r_byp_data : (r_ent_vld ? ram_q : 32'd0);
    assign o_seq_err = (cur != i_seq);

endmodule
